>>> hdl/nla_pkg.sv
// ----------------------------------------------------------------------------
// nla_pkg
// Types and constants for the nearest-lower address lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package nla_pkg;

    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned SLOT_W  = 12;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned GAP_W   = 32;
    localparam int unsigned DATA_W  = 32;

    localparam logic [GAP_W-1:0] GAP_RESET = 32'h0010_0000;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // register indexes
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_MAX_GAP     = 1'b1;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] entry_slot;
        logic [ADDR_W-1:0] entry_address;
        logic [ADDR_W-1:0] query_address;
    } in_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] match_slot;
        logic [GAP_W-1:0]  distance;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

>>> hdl/nla_ram.sv
// ----------------------------------------------------------------------------
// nla_ram
// Single-port synchronous RAM, registered read, read-before-write.
// ----------------------------------------------------------------------------
`default_nettype none

module nla_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> hdl/nearest_lower_address_lookup.sv
// ----------------------------------------------------------------------------
// nearest_lower_address_lookup
// Sorted start-address table with a binary-search predecessor lookup.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------
//  in      | input     | in_valid / in_stall | nla_pkg::in_t  (command)
//  out     | output    | out_valid/out_stall | nla_pkg::out_t (one per lookup)
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
//  A write command produces no transaction on out.
//  A lookup makes P table probes for n searched entries, at most
//  ceil(log2(n + 1)) (13 probes at n = 4096); the single RAM read
//  port sets this, one probe per cycle. Zero queries and an empty table skip
//  the probes. One command is in flight at a time; in_stall is high until
//  it finishes.
//  A result waits in the output register under out_stall; the next command
//  is taken meanwhile, and a further result waits in the result state.
//  Reset clears control state and config; the table is undefined until
//  written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_lower_address_lookup #(
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire nla_pkg::in_t                   in_data,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output nla_pkg::out_t                       out_data,
    // configuration
    input  wire logic                           cfg_write,
    input  wire logic                           cfg_index,
    input  wire logic [nla_pkg::DATA_W-1:0]     cfg_data
);

    import nla_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);     // table index
    localparam int unsigned CW = $clog2(DEPTH + 1); // search bounds, hold DEPTH

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] entry_count_reg;
    logic [GAP_W-1:0]   max_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            max_gap_reg     <= GAP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[COUNT_W-1:0];
                REG_MAX_GAP:     max_gap_reg     <= cfg_data[GAP_W-1:0];
                default:         ;
            endcase
        end
    end

    // entry_count beyond DEPTH searches the whole table
    logic [31:0]   count_wide;
    logic [CW-1:0] count_eff;

    always_comb
    begin
        count_wide = (32'(entry_count_reg) > 32'(DEPTH)) ? 32'(DEPTH)
                                                         : 32'(entry_count_reg);
        count_eff  = count_wide[CW-1:0];
    end

    // ------------------------------------------------------------------
    // address table
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [ADDR_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_rdata;

    nla_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // search state
    // ------------------------------------------------------------------
    state_t            state_reg,  state_next;
    logic [CW-1:0]     lo_reg,     lo_next;
    logic [CW-1:0]     hi_reg,     hi_next;
    logic [CW-1:0]     mid_reg,    mid_next;
    logic [ADDR_W-1:0] query_reg,  query_next;
    logic [ADDR_W-1:0] cand_reg,   cand_next;   // entry[lo - 1]
    logic              miss_reg,   miss_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_reg,    out_next;

    logic              in_take;
    logic              out_free;
    logic [31:0]       slot_wide;
    logic              slot_in_range;
    logic              probe_le;
    logic [CW-1:0]     lo_p, hi_p;
    logic [CW:0]       bound_sum;
    logic [CW-1:0]     mid_p;
    logic [ADDR_W-1:0] gap;
    logic [CW-1:0]     lo_m1;
    logic [31:0]       lo_m1_wide;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        slot_wide     = 32'(in_data.entry_slot);
        slot_in_range = slot_wide < 32'(DEPTH);

        // one probe: RAM data belongs to mid_reg
        probe_le  = (ram_rdata <= query_reg);
        lo_p      = probe_le ? (mid_reg + CW'(1)) : lo_reg;
        hi_p      = probe_le ? hi_reg : mid_reg;
        bound_sum = {1'b0, lo_p} + {1'b0, hi_p};
        mid_p     = bound_sum[CW:1];

        gap        = query_reg - cand_reg;
        lo_m1      = lo_reg - CW'(1);
        lo_m1_wide = 32'(lo_m1);
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        query_next     = query_reg;
        cand_next      = cand_reg;
        miss_next      = miss_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        ram_we    = 1'b0;
        ram_addr  = mid_reg[AW-1:0];
        ram_wdata = in_data.entry_address;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_data.command == CMD_WRITE)
                    begin
                        ram_we   = slot_in_range;
                        ram_addr = slot_wide[AW-1:0];
                    end
                    else
                    begin
                        query_next = in_data.query_address;
                        lo_next    = '0;
                        hi_next    = count_eff;
                        mid_next   = count_eff >> 1;
                        ram_addr   = mid_next[AW-1:0];
                        if ((in_data.query_address == '0) || (count_eff == '0))
                        begin
                            miss_next  = 1'b1;
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            miss_next  = 1'b0;
                            state_next = ST_PROBE;
                        end
                    end
                end
            end

            ST_PROBE:
            begin
                lo_next = lo_p;
                hi_next = hi_p;
                if (probe_le)
                begin
                    cand_next = ram_rdata;
                end
                if (lo_p < hi_p)
                begin
                    mid_next = mid_p;
                    ram_addr = mid_p[AW-1:0];
                end
                else
                begin
                    miss_next  = (lo_p == '0);
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (miss_reg || (gap > ADDR_W'(max_gap_reg)))
                    begin
                        out_next = '0;
                    end
                    else
                    begin
                        out_next.hit        = 1'b1;
                        out_next.match_slot = lo_m1_wide[SLOT_W-1:0];
                        out_next.distance   = gap[GAP_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        query_reg <= query_next;
        cand_reg  <= cand_next;
        miss_reg  <= miss_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire
